// File: sv/pdwt_pkg.sv
// Package for the one-level periodic wavelet transform block.
// Field widths, item codes and the controller/datapath command and status types.
// No dependencies.
`timescale 1ns / 1ps

package pdwt_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int COEF_BITS    = 16;
  localparam int TAP_IDX_BITS = 4;
  localparam int FLEN_BITS    = 5;
  localparam int POS_BITS     = 6;
  localparam int RES_BITS     = 20;
  localparam int RES_MAX      = 2 ** (RES_BITS - 1) - 1;
  localparam int RES_MIN      = -(2 ** (RES_BITS - 1));
  localparam int FRAC_BITS    = 15;
  localparam int FLEN_RESET   = 2;

  // item kind codes
  localparam logic KIND_TAP    = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic load;      // input transfer taken
    logic start;     // begin transform at position 0
    logic issue;     // one tap read for the current position
    logic emit;      // load the output register
    logic next_pos;  // step to the next position
    logic finish;    // empty the sample store
  } pdwt_cmd_t;

  typedef struct packed {
    logic start_work;  // current input item is a last sample and there is work
    logic last_tap;    // tap being issued is the final one
    logic busy;        // MAC pipeline still holds products
    logic out_free;    // output register can take a result this cycle
    logic last_pos;    // current position is the final one of the block
  } pdwt_stat_t;

endpackage

// File: sv/pdwt_in_if.sv
// Input channel: tap pairs and samples with valid/ready.
// Depends on pdwt_pkg for field widths.
`timescale 1ns / 1ps

interface pdwt_in_if;
  logic                                      valid;
  logic                                      ready;
  logic                                      kind;
  logic        [pdwt_pkg::TAP_IDX_BITS-1:0]  tap_index;
  logic signed [pdwt_pkg::COEF_BITS-1:0]     high_coef;
  logic signed [pdwt_pkg::COEF_BITS-1:0]     low_coef;
  logic signed [pdwt_pkg::SAMPLE_BITS-1:0]   sample;
  logic                                      last;

  modport source (output valid, kind, tap_index, high_coef, low_coef, sample, last,
                  input ready);
  modport sink   (input valid, kind, tap_index, high_coef, low_coef, sample, last,
                  output ready);
endinterface

// File: sv/pdwt_out_if.sv
// Result channel: one wavelet/scaling pair per transfer with valid/ready.
// Depends on pdwt_pkg for field widths.
`timescale 1ns / 1ps

interface pdwt_out_if;
  logic                                  valid;
  logic                                  ready;
  logic        [pdwt_pkg::POS_BITS-1:0]  position;
  logic signed [pdwt_pkg::RES_BITS-1:0]  wavelet_coef;
  logic signed [pdwt_pkg::RES_BITS-1:0]  scaling_coef;
  logic                                  final_res;

  modport source (output valid, position, wavelet_coef, scaling_coef, final_res,
                  input ready);
  modport sink   (input valid, position, wavelet_coef, scaling_coef, final_res,
                  output ready);
endinterface

// File: sv/pdwt_cfg_if.sv
// Configuration write channel for the filter length register.
// Depends on pdwt_pkg for the register width.
`timescale 1ns / 1ps

interface pdwt_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pdwt_pkg::FLEN_BITS-1:0]    filter_length;

  modport source (output valid, filter_length, input ready);
  modport sink   (input valid, filter_length, output ready);
endinterface

// File: sv/periodic_dwt_one_level_core.sv
// Top level of the one-level periodic wavelet transform block.
// Depends on pdwt_pkg, the three channel interfaces, pdwt_ctrl and pdwt_dpath.
`timescale 1ns / 1ps
//
// channel  direction  carries
// in_i     sink       tap pair (kind 0) or sample (kind 1), last starts the block
// out_o    source     position, wavelet and scaling coefficient, final flag
// cfg_i    sink       filter_length, always ready
//
// Tap and sample items are taken one per cycle while in_i.ready is high. A last sample
// with two or more stored samples starts the transform: each result pair is built
// one tap per cycle through the sample store read port and the MAC pair, followed
// by a drain of the MAC pipeline and an emit step. in_i.ready is low until the final
// pair is in the output register. A stalled out_o holds the emit step. No clearing
// pass after reset; filter_length resets to 2.

module periodic_dwt_one_level_core #(
  parameter int MAX_SAMPLES = 128,
  parameter int MAX_TAPS    = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  pdwt_in_if.sink    in_i,
  pdwt_out_if.source out_o,
  pdwt_cfg_if.sink   cfg_i
);

  pdwt_pkg::pdwt_cmd_t  cmd;
  pdwt_pkg::pdwt_stat_t stat;

  assign cfg_i.ready = 1'b1;

  pdwt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pdwt_dpath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MAX_TAPS    (MAX_TAPS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .kind_i         (in_i.kind),
    .tap_index_i    (in_i.tap_index),
    .high_coef_i    (in_i.high_coef),
    .low_coef_i     (in_i.low_coef),
    .sample_i       (in_i.sample),
    .last_i         (in_i.last),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_data_i     (cfg_i.filter_length),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .position_o     (out_o.position),
    .wavelet_coef_o (out_o.wavelet_coef),
    .scaling_coef_o (out_o.scaling_coef),
    .final_res_o    (out_o.final_res)
  );

endmodule

// File: sv/pdwt_ctrl.sv
// Sequencer for the wavelet block: item intake, tap issue, pipeline drain, emit.
// Depends on pdwt_pkg for the command and status types.
`timescale 1ns / 1ps

module pdwt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pdwt_pkg::pdwt_stat_t stat_i,
  output pdwt_pkg::pdwt_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (stat_i.start_work) begin
            cmd_o.start = 1'b1;
            state_d     = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        cmd_o.issue = 1'b1;
        if (stat_i.last_tap) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!stat_i.busy) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.last_pos) begin
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
          end else begin
            cmd_o.next_pos = 1'b1;
            state_d        = S_ISSUE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/pdwt_dpath.sv
// Datapath for the wavelet block: tap tables, sample store, address walk,
// dual MAC pipeline, rounding/saturation and the output register.
// Depends on pdwt_pkg for widths, codes and the command/status types.
`timescale 1ns / 1ps

module pdwt_dpath #(
  parameter int MAX_SAMPLES = 128,
  parameter int MAX_TAPS    = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  pdwt_pkg::pdwt_cmd_t                      cmd_i,
  output pdwt_pkg::pdwt_stat_t                     stat_o,
  input  logic                                     kind_i,
  input  logic        [pdwt_pkg::TAP_IDX_BITS-1:0] tap_index_i,
  input  logic signed [pdwt_pkg::COEF_BITS-1:0]    high_coef_i,
  input  logic signed [pdwt_pkg::COEF_BITS-1:0]    low_coef_i,
  input  logic signed [pdwt_pkg::SAMPLE_BITS-1:0]  sample_i,
  input  logic                                     last_i,
  input  logic                                     cfg_valid_i,
  input  logic        [pdwt_pkg::FLEN_BITS-1:0]    cfg_data_i,
  input  logic                                     out_ready_i,
  output logic                                     out_valid_o,
  output logic        [pdwt_pkg::POS_BITS-1:0]     position_o,
  output logic signed [pdwt_pkg::RES_BITS-1:0]     wavelet_coef_o,
  output logic signed [pdwt_pkg::RES_BITS-1:0]     scaling_coef_o,
  output logic                                     final_res_o
);

  localparam int AW     = $clog2(MAX_SAMPLES);
  localparam int CW     = $clog2(MAX_SAMPLES + 1);
  localparam int NW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int PROD_W = pdwt_pkg::COEF_BITS + pdwt_pkg::SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS + 1);
  localparam int EXT_W  = ACC_W + pdwt_pkg::RES_BITS;
  localparam int LW     = pdwt_pkg::FLEN_BITS + 1;

  localparam logic [LW-1:0] MAX_TAPS_L = LW'(MAX_TAPS);
  localparam logic [CW-1:0] MAX_SAMP_C = CW'(MAX_SAMPLES);
  localparam logic signed [EXT_W-1:0] HALF_LSB = EXT_W'(2 ** (pdwt_pkg::FRAC_BITS - 1));
  localparam logic signed [EXT_W-1:0] SAT_HI   = EXT_W'(pdwt_pkg::RES_MAX);
  localparam logic signed [EXT_W-1:0] SAT_LO   = EXT_W'(pdwt_pkg::RES_MIN);

  // round half up by FRAC_BITS, then clamp to the result range
  function automatic logic signed [pdwt_pkg::RES_BITS-1:0] round_sat(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [EXT_W-1:0] r;
    logic signed [EXT_W-1:0] q;
    r = EXT_W'(acc) + HALF_LSB;
    q = r >>> pdwt_pkg::FRAC_BITS;
    if (q > SAT_HI) begin
      q = SAT_HI;
    end else if (q < SAT_LO) begin
      q = SAT_LO;
    end
    return pdwt_pkg::RES_BITS'(q);
  endfunction

  // storage
  logic signed [pdwt_pkg::SAMPLE_BITS-1:0] mem_q [MAX_SAMPLES];
  logic signed [pdwt_pkg::COEF_BITS-1:0]   high_taps_q [MAX_TAPS];
  logic signed [pdwt_pkg::COEF_BITS-1:0]   low_taps_q  [MAX_TAPS];

  logic [CW-1:0]                 count_q, count_d, count_inc;
  logic [pdwt_pkg::FLEN_BITS-1:0] flen_q;
  logic [LW-1:0]                 flen_eff;
  logic [AW-1:0]                 t_q, t_inc, u_q;
  logic [NW-1:0]                 n_q;
  logic                          store_room, is_sample, tap_ok;

  // MAC pipeline
  logic                                    v1_q, v2_q, f1_q, f2_q;
  logic signed [pdwt_pkg::SAMPLE_BITS-1:0] sr_q;
  logic signed [pdwt_pkg::COEF_BITS-1:0]   hr_q, lr_q;
  logic signed [PROD_W-1:0]                ph_q, pl_q;
  logic signed [ACC_W-1:0]                 acch_q, accl_q;

  logic out_valid_q;

  assign is_sample  = (kind_i == pdwt_pkg::KIND_SAMPLE);
  assign store_room = (count_q < MAX_SAMP_C);
  assign count_inc  = store_room ? count_q + CW'(1) : count_q;
  assign tap_ok     = (LW'(tap_index_i) < MAX_TAPS_L);
  assign t_inc      = t_q + AW'(1);

  always_comb begin
    flen_eff = LW'(flen_q);
    if (flen_eff == '0) begin
      flen_eff = LW'(1);
    end else if (flen_eff > MAX_TAPS_L) begin
      flen_eff = MAX_TAPS_L;
    end
  end

  assign stat_o.start_work = is_sample && last_i && (count_inc >= CW'(2));
  assign stat_o.last_tap   = (LW'(n_q) + LW'(1) == flen_eff);
  assign stat_o.busy       = v1_q || v2_q;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;
  assign stat_o.last_pos   = (CW'(t_q) + CW'(1) == (count_q >> 1));

  // sample count; a last sample with too little data just empties the store
  always_comb begin
    count_d = count_q;
    if (cmd_i.load && is_sample) begin
      count_d = count_inc;
      if (last_i && !stat_o.start_work) begin
        count_d = '0;
      end
    end
    if (cmd_i.finish) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      flen_q  <= pdwt_pkg::FLEN_BITS'(pdwt_pkg::FLEN_RESET);
    end else begin
      count_q <= count_d;
      if (cfg_valid_i) begin
        flen_q <= cfg_data_i;
      end
    end
  end

  // sample store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && is_sample && store_room) begin
      mem_q[AW'(count_q)] <= sample_i;
    end
    if (cmd_i.issue) begin
      sr_q <= mem_q[u_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !is_sample && tap_ok) begin
      high_taps_q[NW'(tap_index_i)] <= high_coef_i;
      low_taps_q[NW'(tap_index_i)]  <= low_coef_i;
    end
    if (cmd_i.issue) begin
      hr_q <= high_taps_q[n_q];
      lr_q <= low_taps_q[n_q];
    end
  end

  // address walk: u starts at 2t+1 and steps back, wrapping to m-1
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      t_q <= '0;
      n_q <= '0;
      u_q <= AW'(1);
    end else if (cmd_i.next_pos) begin
      t_q <= t_inc;
      n_q <= '0;
      u_q <= AW'({t_inc, 1'b1});
    end else if (cmd_i.issue) begin
      n_q <= n_q + NW'(1);
      u_q <= (u_q == '0) ? AW'(count_q - CW'(1)) : u_q - AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_q <= (n_q == '0);
    f2_q <= f1_q;
    ph_q <= hr_q * sr_q;
    pl_q <= lr_q * sr_q;
    if (v2_q) begin
      acch_q <= f2_q ? ACC_W'(ph_q) : acch_q + ACC_W'(ph_q);
      accl_q <= f2_q ? ACC_W'(pl_q) : accl_q + ACC_W'(pl_q);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      position_o     <= pdwt_pkg::POS_BITS'(t_q);
      wavelet_coef_o <= round_sat(acch_q);
      scaling_coef_o <= round_sat(accl_q);
      final_res_o    <= stat_o.last_pos;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken result");

  a_emit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !(v1_q || v2_q))
    else $error("result loaded before the MAC pipeline drained");

  a_addr_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> (CW'(u_q) < count_q))
    else $error("sample address beyond the stored block");

  a_final_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && stat_o.last_pos) |=> (count_q == '0) && final_res_o)
    else $error("final result did not empty the store");
`endif

endmodule
